@@ hw/rtl/distinct_subsequence_counter_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the distinct subsequence counter
// Concurrent check wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_SUBSEQUENCE_COUNTER_TOP_DEFINES_SVH
`define DISTINCT_SUBSEQUENCE_COUNTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define DSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define DSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DSC_ASSERT_NOW(lbl, ante, cons, msg)
`define DSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/dsc_pkg.sv @@
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types and fixed widths for the distinct subsequence counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned INDEX_W  = 7;
  localparam int unsigned LEN_W    = 8;

  // Request codes carried by the req_type field.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEXT = 1'b1;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic                load_en;
    logic                text_en;
    logic                first;
    logic [INDEX_W-1:0]  index;
    logic [SYMBOL_W-1:0] symbol;
  } dsc_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/dsc_cell.sv @@
// ----------------------------------------------------------------------------
// dsc_cell
// One pattern position: holds its pattern character and its prefix count,
// and adds the count handed in by its left neighbor on a matching character.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_cell
  import dsc_pkg::*;
#(
  parameter int unsigned CELL_POS    = 1,
  parameter int unsigned LW          = 8,
  parameter int unsigned COUNT_WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dsc_ctl_t               ctl,
  input  wire logic [LW-1:0]          active_len,
  input  wire logic [COUNT_WIDTH-1:0] prev_count,
  output logic      [COUNT_WIDTH-1:0] count_o
);

  logic [SYMBOL_W-1:0]    sym_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic [COUNT_WIDTH-1:0] base;
  logic [COUNT_WIDTH-1:0] addend;
  logic [COUNT_WIDTH:0]   sum;
  logic                   idx_hit;
  logic                   active;
  logic                   match;

  // Pattern character write for this position.
  assign idx_hit = (CELL_POS <= (1 << INDEX_W)) &&
                   (ctl.index == INDEX_W'(CELL_POS - 1));

  always_ff @(posedge clk) begin
    if (ctl.load_en && idx_hit) begin
      sym_r <= ctl.symbol;
    end
  end

  // A first word sees cleared counts: only the empty prefix holds one.
  assign active = (LW'(CELL_POS) <= active_len);
  assign match  = ctl.text_en && active && (sym_r == ctl.symbol);
  assign base   = ctl.first ? '0 : count_r;
  assign addend = ctl.first ? ((CELL_POS == 1) ? COUNT_WIDTH'(1) : '0) : prev_count;
  assign sum    = {1'b0, base} + {1'b0, addend};

  always_comb begin
    count_nxt = count_r;
    if (ctl.text_en) begin
      if (match) begin
        count_nxt = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
      end else begin
        count_nxt = base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count_o = count_r;

endmodule

`default_nettype wire

@@ hw/rtl/distinct_subsequence_counter_top.sv @@
// A last text word sets a pending read, which loads the output register once free.
// Throughput: one word per cycle when not stalled; every cell updates in parallel.
// A pending result that cannot move to the output register stalls the input.
// Reset (rst_n low, synchronous) clears all counts, the length register and handshakes.
// Pattern characters are not reset; they hold whatever was last loaded.
// ----------------------------------------------------------------------------
// distinct_subsequence_counter_top
// Counts subsequence occurrences of a loaded pattern in a streamed text with
// a chain of per-position cells and a registered read of the selected count.
// ----------------------------------------------------------------------------
`default_nettype none
`include "distinct_subsequence_counter_top_defines.svh"

module distinct_subsequence_counter_top
  import dsc_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 128,
  parameter int unsigned COUNT_WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [LEN_W-1:0]       cfg_wr_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_req_type,
  input  wire logic [INDEX_W-1:0]     in_pattern_index,
  input  wire logic [SYMBOL_W-1:0]    in_symbol,
  input  wire logic                   in_text_first,
  input  wire logic                   in_text_last,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic      [COUNT_WIDTH-1:0] out_occurrence_count,
  output logic                        out_saturated
);

  localparam int unsigned LW = $clog2(PATTERN_MAX + 1);

  logic [LEN_W-1:0]       pattern_len_r;
  logic [LW-1:0]          active_len;
  logic                   in_accept;
  logic                   out_free;
  logic                   pend_r;
  logic                   pend_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [COUNT_WIDTH-1:0] out_count_r;
  logic [COUNT_WIDTH-1:0] sel_count;
  dsc_ctl_t               ctl;
  logic [COUNT_WIDTH-1:0] cnt [0:PATTERN_MAX];

  // Length register; values beyond the chain are clamped to its length.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_len_r <= '0;
    end else if (cfg_wr_en) begin
      pattern_len_r <= cfg_wr_data;
    end
  end

  assign active_len = (32'(pattern_len_r) > 32'(PATTERN_MAX)) ?
                      LW'(PATTERN_MAX) : LW'(pattern_len_r);

  // Handshake: the chain holds only while a result waits for the output register.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = pend_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  assign ctl.load_en = in_accept && (in_req_type == REQ_LOAD);
  assign ctl.text_en = in_accept && (in_req_type == REQ_TEXT);
  assign ctl.first   = in_text_first;
  assign ctl.index   = in_pattern_index;
  assign ctl.symbol  = in_symbol;

  // Chain of cells; the empty prefix is the constant one.
  assign cnt[0] = COUNT_WIDTH'(1);

  for (genvar g = 1; g <= PATTERN_MAX; g++) begin : g_cell
    dsc_cell #(
      .CELL_POS    (g),
      .LW          (LW),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .active_len (active_len),
      .prev_count (cnt[g-1]),
      .count_o    (cnt[g])
    );
  end

  // AND-OR select of the count at the active pattern length.
  always_comb begin
    sel_count = '0;
    for (int k = 0; k <= PATTERN_MAX; k++) begin
      sel_count = sel_count | (cnt[k] & {COUNT_WIDTH{active_len == LW'(k)}});
    end
  end

  // Pending read and output register control.
  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pend_r && out_free) begin
      pend_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end
    if (ctl.text_en && in_text_last) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r && out_free) begin
      out_count_r <= sel_count;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_occurrence_count = out_count_r;
  assign out_saturated        = &out_count_r;

  // Checks on the readout control.
  `DSC_ASSERT_NOW(a_stall_needs_pend, in_stall, pend_r, "input stalled without a pending result")
  `DSC_ASSERT_NEXT(a_last_sets_pend, ctl.text_en && in_text_last, pend_r, "last word did not raise pending read")
  `DSC_ASSERT_NEXT(a_pend_moves_out, pend_r && out_free, out_valid_r, "pending result not moved to output")
  `DSC_ASSERT_NEXT(a_out_holds, out_valid_r && out_stall, out_valid_r && $stable(out_count_r), "stalled result word changed")

endmodule

`default_nettype wire
